FILE: rtl/tsi_pkg.sv
// Package for the trie sequence inserter: sizes, codes and payload types.
// Used by every module in the rtl folder except tsi_ram; depends on nothing.
package tsi_pkg;

  localparam int NODES      = 1024;
  localparam int NODE_W     = $clog2(NODES);
  localparam int ALPHA_MAX  = 16;
  localparam int SYM_W      = $clog2(ALPHA_MAX);
  localparam int ALPHA_W    = SYM_W + 1;
  localparam int LEAF_W     = NODE_W + 1;
  localparam int SUCC_DEPTH = NODES * ALPHA_MAX;
  localparam int SUCC_AW    = NODE_W + SYM_W;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [NODE_W-1:0] LAST_NODE  = NODE_W'(NODES - 1);
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(ALPHA_MAX);

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_ALPHABET_SIZE = 1'b0;

  typedef enum logic [2:0] {
    STS_EXISTING  = 3'd0,
    STS_CREATED   = 3'd1,
    STS_FULL      = 3'd2,
    STS_BAD_START = 3'd3,
    STS_BAD_SYM   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_CLEAR
  } fsm_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] start_node;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_reached;
    logic [2:0]        status;
    logic [LEAF_W-1:0] leaf_count;
  } out_item_t;

  // Write request from the controller to one of the memories.
  typedef struct packed {
    logic                 we;
    logic [SUCC_AW-1:0]   addr;
    logic [NODE_W-1:0]    data;
  } succ_wr_t;

  typedef struct packed {
    logic                 we;
    logic [NODE_W-1:0]    addr;
    logic [ALPHA_MAX-1:0] data;
  } mask_wr_t;

endpackage

FILE: rtl/trie_sequence_insert_top.sv
// Top level of the trie sequence inserter.
// Depends on tsi_pkg, tsi_cfg, tsi_ctrl and tsi_ram.
//
// The block inserts symbol sequences into a prefix tree, one symbol per
// transaction, and reports the node reached, a status and the running number
// of leaves. A transaction is taken at a rising edge where start is high and
// busy is low; its result appears on out_data, marked by out_valid, which is
// high for exactly one cycle, and the receiver cannot hold it off. Following
// an existing edge, or any error, first reads the successor and child-mask
// memories (both have a registered read) and then decides and writes back.
// Creating a node adds a clearing step, because the fresh node's child-mask
// row is cleared through the single write port of the mask memory after its
// parent's row has been updated. After reset the block clears the root's row,
// with busy high; rows of other nodes are cleared as each node is allocated,
// so the successor table itself needs no clearing pass. The alphabet size
// register may be written only while the block is idle.
module trie_sequence_insert_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tsi_pkg::in_item_t           in_data,
  output logic                        out_valid,
  output tsi_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsi_pkg::APB_AW-1:0]  paddr,
  input  logic [tsi_pkg::APB_DW-1:0]  pwdata,
  output logic [tsi_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import tsi_pkg::*;

  logic [ALPHA_W-1:0]   alphabet_size;
  logic [SUCC_AW-1:0]   succ_raddr;
  logic [NODE_W-1:0]    succ_rdata;
  succ_wr_t             succ_wr;
  logic [NODE_W-1:0]    mask_raddr;
  logic [ALPHA_MAX-1:0] mask_rdata;
  mask_wr_t             mask_wr;

  tsi_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .alphabet_size (alphabet_size)
  );

  tsi_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .alphabet_size (alphabet_size),
    .succ_raddr    (succ_raddr),
    .succ_rdata    (succ_rdata),
    .succ_wr       (succ_wr),
    .mask_raddr    (mask_raddr),
    .mask_rdata    (mask_rdata),
    .mask_wr       (mask_wr)
  );

  // Successor table: one row of ALPHA_MAX child pointers per node. An entry
  // is only trusted when the matching bit of its node's child mask is set.
  tsi_ram #(
    .WIDTH (NODE_W),
    .DEPTH (SUCC_DEPTH)
  ) u_succ_ram (
    .clk   (clk),
    .we    (succ_wr.we),
    .waddr (succ_wr.addr),
    .wdata (succ_wr.data),
    .raddr (succ_raddr),
    .rdata (succ_rdata)
  );

  // Child mask: one bit per symbol and node; a node is a leaf when its row
  // is all zero.
  tsi_ram #(
    .WIDTH (ALPHA_MAX),
    .DEPTH (NODES)
  ) u_mask_ram (
    .clk   (clk),
    .we    (mask_wr.we),
    .waddr (mask_wr.addr),
    .wdata (mask_wr.data),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

endmodule

FILE: rtl/tsi_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tsi_cfg.sv
// Configuration register file behind the APB-style port (alphabet size).
// Depends on tsi_pkg.
module tsi_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsi_pkg::APB_AW-1:0]  paddr,
  input  logic [tsi_pkg::APB_DW-1:0]  pwdata,
  output logic [tsi_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [tsi_pkg::ALPHA_W-1:0] alphabet_size
);
  import tsi_pkg::*;

  logic [ALPHA_W-1:0] alpha_r;
  logic [ALPHA_W-1:0] alpha_nxt;
  logic               wr_en;
  logic               reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    alpha_nxt = alpha_r;
    if (wr_en && (reg_idx == REG_ALPHABET_SIZE)) begin
      alpha_nxt = pwdata[ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
    end else begin
      alpha_r <= alpha_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_ALPHABET_SIZE) begin
      prdata = APB_DW'(alpha_r);
    end
  end

  assign alphabet_size = alpha_r;

endmodule

FILE: rtl/tsi_ctrl.sv
// Walk controller: issues the table reads, decides follow or create, writes back
// and keeps the node, allocation and leaf counters. Depends on tsi_pkg.
module tsi_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tsi_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output tsi_pkg::out_item_t            out_data,
  input  logic [tsi_pkg::ALPHA_W-1:0]   alphabet_size,
  output logic [tsi_pkg::SUCC_AW-1:0]   succ_raddr,
  input  logic [tsi_pkg::NODE_W-1:0]    succ_rdata,
  output tsi_pkg::succ_wr_t             succ_wr,
  output logic [tsi_pkg::NODE_W-1:0]    mask_raddr,
  input  logic [tsi_pkg::ALPHA_MAX-1:0] mask_rdata,
  output tsi_pkg::mask_wr_t             mask_wr
);
  import tsi_pkg::*;

  fsm_t state_r, state_nxt;

  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] high_r, high_nxt;
  logic [LEAF_W-1:0] leaves_r, leaves_nxt;

  // Item held while its table words are read.
  logic [NODE_W-1:0] node_q_r;
  logic [SYM_W-1:0]  sym_q_r;
  logic              bad_start_r;
  logic              bad_sym_r;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              accept;
  logic [NODE_W-1:0] node_sel;
  logic              hit;
  logic              full;
  logic              create;
  logic [NODE_W-1:0] new_node;
  logic [ALPHA_MAX-1:0] sym_bit;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && (state_r == ST_IDLE);
  assign node_sel = in_data.restart ? in_data.start_node : cur_r;

  assign succ_raddr = {node_sel, in_data.symbol};
  assign mask_raddr = node_sel;

  assign sym_bit  = ALPHA_MAX'(1) << sym_q_r;
  assign hit      = mask_rdata[sym_q_r];
  assign full     = (high_r == LAST_NODE);
  assign new_node = high_r + NODE_W'(1);
  assign create   = (state_r == ST_LOOKUP) && !bad_start_r && !bad_sym_r && !hit && !full;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:   state_nxt = ST_IDLE;
      ST_IDLE:   if (accept) begin
                   state_nxt = ST_LOOKUP;
                 end
      ST_LOOKUP: state_nxt = create ? ST_CLEAR : ST_IDLE;
      ST_CLEAR:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_INIT;
    endcase
  end

  // Memory writes.
  always_comb begin
    succ_wr = '0;
    mask_wr = '0;
    case (state_r)
      ST_INIT: begin
        mask_wr.we   = 1'b1;
        mask_wr.addr = '0;
        mask_wr.data = '0;
      end
      ST_LOOKUP: begin
        succ_wr.we   = create;
        succ_wr.addr = {node_q_r, sym_q_r};
        succ_wr.data = new_node;
        mask_wr.we   = create;
        mask_wr.addr = node_q_r;
        mask_wr.data = mask_rdata | sym_bit;
      end
      ST_CLEAR: begin
        // The node just allocated starts with no successors.
        mask_wr.we   = 1'b1;
        mask_wr.addr = high_r;
        mask_wr.data = '0;
      end
      default: begin
        succ_wr = '0;
        mask_wr = '0;
      end
    endcase
  end

  // Counters and the result.
  always_comb begin
    cur_nxt       = cur_r;
    high_nxt      = high_r;
    leaves_nxt    = leaves_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    if (state_r == ST_LOOKUP) begin
      out_valid_nxt = 1'b1;
      if (bad_start_r) begin
        out_data_nxt.node_reached = cur_r;
        out_data_nxt.status       = STS_BAD_START;
      end else if (bad_sym_r) begin
        out_data_nxt.node_reached = cur_r;
        out_data_nxt.status       = STS_BAD_SYM;
      end else if (hit) begin
        cur_nxt                   = succ_rdata;
        out_data_nxt.node_reached = succ_rdata;
        out_data_nxt.status       = STS_EXISTING;
      end else if (full) begin
        out_data_nxt.node_reached = cur_r;
        out_data_nxt.status       = STS_FULL;
      end else begin
        cur_nxt  = new_node;
        high_nxt = new_node;
        // A parent that already had a child gains a leaf; otherwise the
        // leaf simply moves from the parent to the new node.
        if (|mask_rdata) begin
          leaves_nxt = leaves_r + LEAF_W'(1);
        end
        out_data_nxt.node_reached = new_node;
        out_data_nxt.status       = STS_CREATED;
      end
      out_data_nxt.leaf_count = leaves_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_r       <= '0;
      high_r      <= '0;
      leaves_r    <= LEAF_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      high_r      <= high_nxt;
      leaves_r    <= leaves_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      node_q_r    <= node_sel;
      sym_q_r     <= in_data.symbol;
      bad_start_r <= in_data.restart && (in_data.start_node > high_r);
      bad_sym_r   <= {1'b0, in_data.symbol} >= alphabet_size;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
